// File: src/ehp_pkg.sv
// Package for the Ethernet/IPv4 header parser: item types, frame summary
// record passed from the front end to the back end, and protocol codes.
// No dependencies.
package ehp_pkg;

  // IHL counts 32-bit words
  localparam int IhlUnit = 4;

  localparam logic [6:0] PosMax       = 7'd127;
  localparam logic [6:0] EthHdrBytes  = 7'd14;
  localparam logic [6:0] ProtoSeenPos = 7'd24;

  localparam logic [15:0] EtypeIpv4 = 16'h0800;
  localparam logic [15:0] EtypeArp  = 16'h0806;

  localparam logic [7:0] ProtoIcmp = 8'd1;
  localparam logic [7:0] ProtoIgmp = 8'd2;
  localparam logic [7:0] ProtoTcp  = 8'd6;
  localparam logic [7:0] ProtoUdp  = 8'd17;

  // frame_kind codes
  localparam logic [1:0] FkOther = 2'd0;
  localparam logic [1:0] FkIpv4  = 2'd1;
  localparam logic [1:0] FkArp   = 2'd2;

  // transport_kind codes
  localparam logic [2:0] TkNone  = 3'd0;
  localparam logic [2:0] TkTcp   = 3'd1;
  localparam logic [2:0] TkUdp   = 3'd2;
  localparam logic [2:0] TkIcmp  = 3'd3;
  localparam logic [2:0] TkIgmp  = 3'd4;
  localparam logic [2:0] TkOther = 3'd5;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       frame_end;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  frame_kind;
    logic [2:0]  transport_kind;
    logic [47:0] dest_mac;
    logic [47:0] source_mac;
    logic [15:0] ip_total_length;
    logic [31:0] ip_source;
    logic [31:0] ip_dest;
    logic [15:0] port_source;
    logic [15:0] port_dest;
    logic [31:0] tcp_sequence;
    logic [31:0] tcp_acknowledge;
    logic [15:0] sub_code;
  } out_item_t;

  // raw captured header of one frame, not yet classified
  typedef struct packed {
    logic        seen_eth;
    logic        seen_proto;
    logic [15:0] ethertype;
    logic [7:0]  ip_protocol;
    logic [47:0] dest_mac;
    logic [47:0] source_mac;
    logic [15:0] ip_length;
    logic [31:0] ip_source;
    logic [31:0] ip_dest;
    logic [15:0] port_source;
    logic [15:0] port_dest;
    logic [31:0] sequence_num;
    logic [31:0] acknowledge;
    logic [15:0] sub_code;
  } frame_rec_t;

endpackage

// File: src/ehp_front.sv
// Front end of the header parser: byte position tracking and field capture.
// Emits one raw frame record on the last byte. Uses ehp_pkg.
module ehp_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  ehp_pkg::in_item_t   in_item,
  input  logic                rec_full,
  output logic                full,
  output logic                rec_push,
  output ehp_pkg::frame_rec_t rec
);

  logic [6:0]  pos, pos_next;
  logic [5:0]  hdr, hdr_next, hdr_new, hdr_eff;
  logic [6:0]  l4_start, l4_off;
  logic        in_l4, accept;
  logic [7:0]  b;
  ehp_pkg::frame_rec_t held, held_next;

  assign b      = in_item.data_byte;
  assign accept = push && !rec_full;
  assign full   = rec_full;

  // capture the current byte at its place
  always_comb begin
    held_next = held;
    hdr_next  = hdr;
    hdr_new   = 6'(b[3:0] * ehp_pkg::IhlUnit);
    for (int i = 0; i < 6; i++) begin
      if (pos == 7'(i)) held_next.dest_mac[8*(5-i) +: 8] = b;
      if (pos == 7'(6 + i)) held_next.source_mac[8*(5-i) +: 8] = b;
    end
    for (int i = 0; i < 2; i++) begin
      if (pos == 7'(12 + i)) held_next.ethertype[8*(1-i) +: 8] = b;
      if (pos == 7'(16 + i)) held_next.ip_length[8*(1-i) +: 8] = b;
      if (pos == 7'(20 + i)) held_next.sub_code[8*(1-i) +: 8] = b;
    end
    if (pos == ehp_pkg::EthHdrBytes) hdr_next = hdr_new;
    if (pos == 7'd23) held_next.ip_protocol = b;
    for (int i = 0; i < 4; i++) begin
      if (pos == 7'(26 + i)) held_next.ip_source[8*(3-i) +: 8] = b;
      if (pos == 7'(30 + i)) held_next.ip_dest[8*(3-i) +: 8] = b;
    end

    // layer-4 bytes; at byte 14 the new IHL applies at once
    hdr_eff  = (pos == ehp_pkg::EthHdrBytes) ? hdr_new : hdr;
    l4_start = ehp_pkg::EthHdrBytes + {1'b0, hdr_eff};
    in_l4    = (pos >= ehp_pkg::EthHdrBytes) && (pos != ehp_pkg::PosMax) &&
               (pos >= l4_start);
    l4_off   = pos - l4_start;
    for (int i = 0; i < 2; i++) begin
      if (in_l4 && l4_off == 7'(i)) held_next.port_source[8*(1-i) +: 8] = b;
      if (in_l4 && l4_off == 7'(2 + i)) held_next.port_dest[8*(1-i) +: 8] = b;
    end
    for (int i = 0; i < 4; i++) begin
      if (in_l4 && l4_off == 7'(4 + i)) held_next.sequence_num[8*(3-i) +: 8] = b;
      if (in_l4 && l4_off == 7'(8 + i)) held_next.acknowledge[8*(3-i) +: 8] = b;
    end

    pos_next = (pos == ehp_pkg::PosMax) ? pos : pos + 7'd1;
    held_next.seen_eth   = (pos_next >= ehp_pkg::EthHdrBytes);
    held_next.seen_proto = (pos_next >= ehp_pkg::ProtoSeenPos);
  end

  // record goes out on the last byte of the frame
  assign rec_push = accept && in_item.frame_end;
  assign rec      = held_next;

  // state update; a finished frame returns everything to reset
  always_ff @(posedge clk) begin
    if (rst || rec_push) begin
      pos  <= '0;
      hdr  <= '0;
      held <= '0;
    end else if (accept) begin
      pos  <= pos_next;
      hdr  <= hdr_next;
      held <= held_next;
    end
  end

endmodule

// File: src/ehp_fifo.sv
// Short record queue between front and back end of the header parser.
// Uses ehp_pkg for the record type.
module ehp_fifo #(
  parameter int DEPTH = 2
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                wr,
  input  ehp_pkg::frame_rec_t wr_data,
  input  logic                rd,
  output logic                full,
  output logic                not_empty,
  output ehp_pkg::frame_rec_t rd_data
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  ehp_pkg::frame_rec_t mem [DEPTH];
  logic [AW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] count;
  logic          do_wr, do_rd;

  assign full      = (count == CW'(DEPTH));
  assign not_empty = (count != '0);
  assign do_wr     = wr && !full;
  assign do_rd     = rd && not_empty;
  assign rd_data   = mem[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (do_wr) mem[wr_ptr] <= wr_data;
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      if (do_rd) rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      if (do_wr && !do_rd) count <= count + CW'(1);
      else if (do_rd && !do_wr) count <= count - CW'(1);
    end
  end

endmodule

// File: src/ehp_back.sv
// Back end of the header parser: classifies a raw frame record, zeroes the
// fields that do not apply and holds the summary for the consumer. Uses ehp_pkg.
module ehp_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                rec_valid,
  input  ehp_pkg::frame_rec_t rec,
  output logic                rec_take,
  input  logic                pop,
  output logic                empty,
  output ehp_pkg::out_item_t  out_item
);

  logic               out_valid;
  logic [1:0]         fk;
  logic [2:0]         tk;
  ehp_pkg::out_item_t sum;

  assign rec_take = rec_valid && (!out_valid || pop);
  assign empty    = !out_valid;

  // classification and field selection
  always_comb begin
    fk = ehp_pkg::FkOther;
    if (rec.seen_eth) begin
      if (rec.ethertype == ehp_pkg::EtypeIpv4) fk = ehp_pkg::FkIpv4;
      else if (rec.ethertype == ehp_pkg::EtypeArp) fk = ehp_pkg::FkArp;
    end
    tk = ehp_pkg::TkNone;
    if (fk == ehp_pkg::FkIpv4 && rec.seen_proto) begin
      case (rec.ip_protocol)
        ehp_pkg::ProtoTcp:  tk = ehp_pkg::TkTcp;
        ehp_pkg::ProtoUdp:  tk = ehp_pkg::TkUdp;
        ehp_pkg::ProtoIcmp: tk = ehp_pkg::TkIcmp;
        ehp_pkg::ProtoIgmp: tk = ehp_pkg::TkIgmp;
        default:            tk = ehp_pkg::TkOther;
      endcase
    end
    sum                 = '0;
    sum.frame_kind      = fk;
    sum.transport_kind  = tk;
    sum.dest_mac        = rec.dest_mac;
    sum.source_mac      = rec.source_mac;
    if (fk == ehp_pkg::FkIpv4) begin
      sum.ip_total_length = rec.ip_length;
      sum.ip_source       = rec.ip_source;
      sum.ip_dest         = rec.ip_dest;
    end
    if (tk == ehp_pkg::TkTcp || tk == ehp_pkg::TkUdp) begin
      sum.port_source = rec.port_source;
      sum.port_dest   = rec.port_dest;
    end
    if (tk == ehp_pkg::TkTcp) begin
      sum.tcp_sequence    = rec.sequence_num;
      sum.tcp_acknowledge = rec.acknowledge;
    end
    if (fk == ehp_pkg::FkArp) sum.sub_code = rec.sub_code;
    else if (tk == ehp_pkg::TkIcmp) sum.sub_code = {8'h00, rec.port_source[15:8]};
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (rec_take) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rec_take) out_item <= sum;
  end

endmodule

// File: src/ethernet_header_parser.sv
// Top level of the Ethernet/IPv4 header parser.
// Instantiates ehp_front, ehp_fifo and ehp_back; uses ehp_pkg.
//
// Frames enter one byte per item in wire order, starting at the destination
// MAC, with frame_end set on the last byte; one byte is taken every cycle
// while full is low. The byte position compare and field capture in the
// front end finish within the cycle of each byte. On the last byte a raw
// header record enters a QUEUE_DEPTH-entry queue, and the back end
// classifies it into the output register once that register is free or
// being popped; the summary is held there until the consumer pops it.
// full rises only when the queue is full and the output register is still
// unread. Fields the frame never reached read as zero.
module ethernet_header_parser #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  ehp_pkg::in_item_t  in_item,
  output logic               empty,
  input  logic               pop,
  output ehp_pkg::out_item_t out_item
);

  logic                rec_push, rec_full, rec_valid, rec_take;
  ehp_pkg::frame_rec_t rec_in, rec_out;

  ehp_front u_front (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .in_item  (in_item),
    .rec_full (rec_full),
    .full     (full),
    .rec_push (rec_push),
    .rec      (rec_in)
  );

  ehp_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .wr        (rec_push),
    .wr_data   (rec_in),
    .rd        (rec_take),
    .full      (rec_full),
    .not_empty (rec_valid),
    .rd_data   (rec_out)
  );

  ehp_back u_back (
    .clk       (clk),
    .rst       (rst),
    .rec_valid (rec_valid),
    .rec       (rec_out),
    .rec_take  (rec_take),
    .pop       (pop),
    .empty     (empty),
    .out_item  (out_item)
  );

endmodule

// File: dv/tb.sv
// Self-checking testbench for ethernet_header_parser: streams Ethernet frames byte by byte
// and checks each frame summary against a built-in header predictor.
// Depends on ehp_pkg and the ethernet_header_parser RTL.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CycleLimit   = 200_000;
  localparam int DrainCycles  = 20;
  localparam int MaxReported  = 10;

  // per-frame parse state, cleared after every summary
  typedef struct packed {
    logic [6:0]  pos;
    logic [15:0] etype;
    logic [5:0]  ihl_bytes;
    logic [7:0]  proto;
    logic [47:0] dmac;
    logic [47:0] smac;
    logic [15:0] ip_len;
    logic [31:0] ip_src;
    logic [31:0] ip_dst;
    logic [15:0] sport;
    logic [15:0] dport;
    logic [31:0] seq;
    logic [31:0] ack;
    logic [15:0] arp_op;
  } hdr_state_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               push = 1'b0;
  logic               pop = 1'b0;
  logic               full;
  logic               empty;
  ehp_pkg::in_item_t  in_item = '0;
  ehp_pkg::out_item_t out_item;

  hdr_state_t         hdr = '0;
  ehp_pkg::out_item_t summaries_due[$];
  ehp_pkg::out_item_t want;
  logic [7:0]         frame_q[$];
  int                 stall_max = 6;
  int                 pop_wait = 0;
  int                 mismatches = 0;
  int                 summaries_seen = 0;
  int                 cycles = 0;

  ethernet_header_parser uut (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .full     (full),
    .in_item  (in_item),
    .empty    (empty),
    .pop      (pop),
    .out_item (out_item)
  );

  // 4 ns clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles == CycleLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // predictor: update header state with one accepted byte, queue a summary on the last one
  task automatic track_byte(input ehp_pkg::in_item_t it);
    int                 p;
    int                 o;
    int                 seen;
    ehp_pkg::out_item_t s;
    p = hdr.pos;
    if (p < 6) begin
      hdr.dmac[47 - 8*p -: 8] = it.data_byte;
    end else if (p < 12) begin
      hdr.smac[47 - 8*(p-6) -: 8] = it.data_byte;
    end else if (p < 14) begin
      hdr.etype[15 - 8*(p-12) -: 8] = it.data_byte;
    end
    // new IHL takes effect on its own byte
    if (p == 14) hdr.ihl_bytes = 6'(it.data_byte[3:0] * ehp_pkg::IhlUnit);
    if (p >= 16 && p < 18) hdr.ip_len[15 - 8*(p-16) -: 8] = it.data_byte;
    if (p >= 20 && p < 22) hdr.arp_op[15 - 8*(p-20) -: 8] = it.data_byte;
    if (p == 23) hdr.proto = it.data_byte;
    if (p >= 26 && p < 30) hdr.ip_src[31 - 8*(p-26) -: 8] = it.data_byte;
    if (p >= 30 && p < 34) hdr.ip_dst[31 - 8*(p-30) -: 8] = it.data_byte;
    // layer-4 bytes, captured whatever the protocol
    if (p >= ehp_pkg::EthHdrBytes && p < ehp_pkg::PosMax &&
        p >= ehp_pkg::EthHdrBytes + hdr.ihl_bytes) begin
      o = p - ehp_pkg::EthHdrBytes - hdr.ihl_bytes;
      if (o < 2) begin
        hdr.sport[15 - 8*o -: 8] = it.data_byte;
      end else if (o < 4) begin
        hdr.dport[15 - 8*(o-2) -: 8] = it.data_byte;
      end else if (o < 8) begin
        hdr.seq[31 - 8*(o-4) -: 8] = it.data_byte;
      end else if (o < 12) begin
        hdr.ack[31 - 8*(o-8) -: 8] = it.data_byte;
      end
    end
    if (hdr.pos < ehp_pkg::PosMax) hdr.pos++;
    if (it.frame_end) begin
      seen = hdr.pos;
      s = '0;
      s.frame_kind = ehp_pkg::FkOther;
      s.transport_kind = ehp_pkg::TkNone;
      if (seen >= ehp_pkg::EthHdrBytes) begin
        if (hdr.etype == ehp_pkg::EtypeIpv4) s.frame_kind = ehp_pkg::FkIpv4;
        else if (hdr.etype == ehp_pkg::EtypeArp) s.frame_kind = ehp_pkg::FkArp;
      end
      if (s.frame_kind == ehp_pkg::FkIpv4 && seen >= ehp_pkg::ProtoSeenPos) begin
        case (hdr.proto)
          ehp_pkg::ProtoTcp:  s.transport_kind = ehp_pkg::TkTcp;
          ehp_pkg::ProtoUdp:  s.transport_kind = ehp_pkg::TkUdp;
          ehp_pkg::ProtoIcmp: s.transport_kind = ehp_pkg::TkIcmp;
          ehp_pkg::ProtoIgmp: s.transport_kind = ehp_pkg::TkIgmp;
          default:            s.transport_kind = ehp_pkg::TkOther;
        endcase
      end
      s.dest_mac = hdr.dmac;
      s.source_mac = hdr.smac;
      if (s.frame_kind == ehp_pkg::FkIpv4) begin
        s.ip_total_length = hdr.ip_len;
        s.ip_source = hdr.ip_src;
        s.ip_dest = hdr.ip_dst;
      end
      if (s.transport_kind == ehp_pkg::TkTcp || s.transport_kind == ehp_pkg::TkUdp) begin
        s.port_source = hdr.sport;
        s.port_dest = hdr.dport;
      end
      if (s.transport_kind == ehp_pkg::TkTcp) begin
        s.tcp_sequence = hdr.seq;
        s.tcp_acknowledge = hdr.ack;
      end
      if (s.frame_kind == ehp_pkg::FkArp) s.sub_code = hdr.arp_op;
      else if (s.transport_kind == ehp_pkg::TkIcmp) s.sub_code = {8'h00, hdr.sport[15:8]};
      summaries_due.push_back(s);
      hdr = '0;
    end
  endtask

  // send one byte item, with a random gap in front of it
  task automatic send_byte(input logic [7:0] b, input logic last);
    int                gap;
    ehp_pkg::in_item_t it;
    gap = $urandom_range(stall_max, 0);
    it.data_byte = b;
    it.frame_end = last;
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (full);
    track_byte(it);
  endtask

  task automatic send_frame();
    for (int i = 0; i < frame_q.size(); i++) begin
      send_byte(frame_q[i], i == frame_q.size() - 1);
    end
  endtask

  // random bytes with EtherType, IHL and protocol forced where the frame reaches them
  task automatic build_frame(input logic [15:0] etype, input logic [3:0] ihl,
                             input logic [7:0] proto, input int len);
    frame_q.delete();
    for (int i = 0; i < len; i++) frame_q.push_back(8'($urandom));
    if (len > 12) frame_q[12] = etype[15:8];
    if (len > 13) frame_q[13] = etype[7:0];
    if (len > 14) frame_q[14] = {4'($urandom), ihl};
    if (len > 23) frame_q[23] = proto;
  endtask

  // mostly well-formed traffic, some near-miss and junk EtherTypes
  task automatic random_frame(input int ihl_lo, input int ihl_hi,
                              input int len_lo, input int len_hi);
    logic [15:0] et;
    logic [7:0]  pr;
    int          r;
    r = $urandom_range(99, 0);
    if (r < 60) et = ehp_pkg::EtypeIpv4;
    else if (r < 75) et = ehp_pkg::EtypeArp;
    else if (r < 88) et = ehp_pkg::EtypeArp ^ 16'(1 << $urandom_range(15, 0));
    else et = 16'($urandom);
    r = $urandom_range(99, 0);
    if (r < 30) pr = ehp_pkg::ProtoTcp;
    else if (r < 55) pr = ehp_pkg::ProtoUdp;
    else if (r < 70) pr = ehp_pkg::ProtoIcmp;
    else if (r < 80) pr = ehp_pkg::ProtoIgmp;
    else pr = 8'($urandom);
    build_frame(et, 4'($urandom_range(ihl_hi, ihl_lo)), pr, $urandom_range(len_hi, len_lo));
    send_frame();
  endtask

  // truncated frames, all-ones and all-zeros bytes
  task automatic test_short_frames();
    frame_q = '{8'hFF};
    send_frame();
    frame_q = '{8'h00, 8'h00};
    send_frame();
    // ends right after the EtherType
    build_frame(ehp_pkg::EtypeArp, 4'h0, 8'h00, 14);
    for (int i = 0; i < 6; i++) frame_q[i] = 8'hFF;
    for (int i = 6; i < 12; i++) frame_q[i] = 8'h00;
    send_frame();
  endtask

  // IHL below 5: layer-4 start overlaps the IP header
  task automatic test_small_ihl();
    repeat (8) random_frame(0, 4, 15, 45);
  endtask

  // position saturates, later bytes capture nothing
  task automatic test_long_frames();
    repeat (2) random_frame(0, 15, 128, 170);
  endtask

  task automatic test_mixed_traffic();
    int r;
    repeat (19) begin
      r = $urandom_range(99, 0);
      if ($urandom_range(3, 0) == 0) begin
        random_frame(0, 15, 1, 126);
      end else if (r < 55) begin
        random_frame(5, 5, 34, 60);
      end else if (r < 85) begin
        random_frame(5, 5, 1, 34);
      end else begin
        random_frame(5, 5, 60, 126);
      end
    end
  endtask

  // no gaps on either side
  task automatic test_back_to_back();
    stall_max = 0;
    repeat (8) random_frame(5, 5, 20, 60);
    stall_max = 6;
  endtask

  // result side: random wait before each pop
  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
      pop_wait = 0;
    end else if (pop && !empty) begin
      pop_wait = $urandom_range(stall_max, 0);
      pop <= (pop_wait == 0);
    end else if (!pop) begin
      if (pop_wait == 0) pop <= 1'b1;
      else pop_wait--;
    end
  end

  task automatic note_mismatch(input string what, input logic [63:0] exp_v,
                               input logic [63:0] got_v);
    mismatches++;
    if (mismatches <= MaxReported) begin
      $display("summary %0d %s: expected %h got %h", summaries_seen, what, exp_v, got_v);
    end
  endtask

  task automatic check_field(input string what, input logic [63:0] exp_v,
                             input logic [63:0] got_v);
    if (exp_v !== got_v) note_mismatch(what, exp_v, got_v);
  endtask

  // compare every accepted summary with the oldest expectation
  always @(posedge clk) begin
    if (!rst && pop && !empty) begin
      summaries_seen++;
      if (summaries_due.size() == 0) begin
        note_mismatch("unexpected summary, dest_mac", 64'h0, out_item.dest_mac);
      end else begin
        want = summaries_due.pop_front();
        check_field("frame_kind", want.frame_kind, out_item.frame_kind);
        check_field("transport_kind", want.transport_kind, out_item.transport_kind);
        check_field("dest_mac", want.dest_mac, out_item.dest_mac);
        check_field("source_mac", want.source_mac, out_item.source_mac);
        check_field("ip_total_length", want.ip_total_length, out_item.ip_total_length);
        check_field("ip_source", want.ip_source, out_item.ip_source);
        check_field("ip_dest", want.ip_dest, out_item.ip_dest);
        check_field("port_source", want.port_source, out_item.port_source);
        check_field("port_dest", want.port_dest, out_item.port_dest);
        check_field("tcp_sequence", want.tcp_sequence, out_item.tcp_sequence);
        check_field("tcp_acknowledge", want.tcp_acknowledge, out_item.tcp_acknowledge);
        check_field("sub_code", want.sub_code, out_item.sub_code);
      end
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    test_short_frames();
    test_small_ihl();
    test_long_frames();
    test_mixed_traffic();
    test_back_to_back();
    push <= 1'b0;
    // drain, then watch for stray summaries
    while (summaries_due.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// File: files.f
src/ehp_pkg.sv
src/ehp_front.sv
src/ehp_fifo.sv
src/ehp_back.sv
src/ethernet_header_parser.sv
dv/tb.sv
